[hdl/eps_pkg.sv]
`default_nettype none

package eps_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_GAIN_P     = 3'd0;
   localparam logic [2:0] REG_GAIN_I     = 3'd1;
   localparam logic [2:0] REG_GAIN_D     = 3'd2;
   localparam logic [2:0] REG_INV_PERIOD = 3'd3;
   localparam logic [2:0] REG_INVERT     = 3'd4;
   localparam logic [2:0] REG_POS_PERIOD = 3'd5;
   localparam logic [2:0] REG_NEG_PERIOD = 3'd6;
   localparam logic [2:0] REG_NEG_ENABLE = 3'd7;

   // shared serial multiplier: signed multiplicand x signed multiplier
   localparam int MUL_A_W   = 49;
   localparam int MUL_B_W   = 33;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // serial divide-by-five
   localparam int DIV_W     = 35;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam logic [3:0] DIV_BY = 4'd5;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

[hdl/encoder_speed_pid_pwm.sv]
// Encoder speed PID controller with forward and reverse PWM compare outputs.
//
// req channel: one transaction per control tick carries the raw 16-bit encoder
// count and the signed Q16.16 target speed. rsp channel: one transaction per
// tick carries the forward and reverse compare values, the measured speed and
// the smoothed speed. csr port: gains, reciprocal period, invert, PWM periods
// and reverse enable, which the user must write only while no tick is in
// flight; the block itself does not enforce this.
//
// Each tick runs five multiplies (speed, P, I, D, duty) through one bit-serial
// shift-add unit, 33 multiplier bits at one bit per cycle; the speed average is
// divided by five bit-serially alongside the P multiply. A new tick is taken
// the cycle after the previous one has moved into the output register.
//
// Reset (synchronous) clears the state and loads the register defaults.
// A stalled rsp holds its data; req is still taken and the next tick waits
// in its final state until the output register is free.
`default_nettype none

module encoder_speed_pid_pwm (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // encoder_count[15:0], target_speed[47:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [95:0] rsp_tdata,   // pos_duty[15:0], neg_duty[31:16],
                                         // measured_speed[63:32], smoothed_speed[95:64]
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import eps_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SPD_GO  = 4'd1;
   localparam logic [3:0] S_SPD     = 4'd2;
   localparam logic [3:0] S_ERR     = 4'd3;
   localparam logic [3:0] S_ERR2    = 4'd4;
   localparam logic [3:0] S_PMUL    = 4'd5;
   localparam logic [3:0] S_I_GO    = 4'd6;
   localparam logic [3:0] S_IMUL    = 4'd7;
   localparam logic [3:0] S_D_GO    = 4'd8;
   localparam logic [3:0] S_DMUL    = 4'd9;
   localparam logic [3:0] S_CLAMP   = 4'd10;
   localparam logic [3:0] S_DUTY_GO = 4'd11;
   localparam logic [3:0] S_DUTY    = 4'd12;
   localparam logic [3:0] S_OUT     = 4'd13;

   localparam int DRV_W = MUL_P_W - 16;
   localparam logic signed [DRV_W-1:0]   DRV_MAX   = DRV_W'(64'sd16777216);
   localparam logic signed [DRV_W-1:0]   DRV_MIN   = DRV_W'(-64'sd16777216);
   localparam logic signed [MUL_P_W-1:0] P_S32_MAX = MUL_P_W'(64'sh7FFF_FFFF);
   localparam logic signed [MUL_P_W-1:0] P_S32_MIN = MUL_P_W'(-64'sh8000_0000);
   localparam logic [24:0] MAG_ONE   = 25'h100_0000;
   localparam logic [40:0] ROUND_HALF = 41'h80_0000;

   function automatic logic [31:0] sat33(input logic [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return v[31:0];
   endfunction

   // configuration
   logic [31:0] gain_p_ff, gain_i_ff, gain_d_ff, inv_period_ff;
   logic        invert_ff, neg_enable_ff;
   logic [15:0] pos_period_ff, neg_period_ff;

   // control and state
   logic [3:0]  state_ff, state_in;
   logic [15:0] prev_count_ff;
   logic [31:0] prev_error_ff;
   logic [47:0] esum_ff;
   logic [31:0] speed_average_ff;

   // per-tick working registers
   logic [15:0] diff_ff;
   logic [31:0] target_ff;
   logic [31:0] speed_ff;
   logic [31:0] err_ff;
   logic [31:0] dterm_ff;
   logic        acc_neg_ff;
   logic [DRV_W-1:0] drive_ff;
   logic [24:0] mag_ff;
   logic        drv_pos_ff, drv_neg_ff;
   logic [15:0] pos_duty_ff, neg_duty_ff;
   logic        rsp_valid_ff;
   logic [95:0] rsp_data_ff;

   // units
   logic                 mul_start;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   mul_prod;
   unit_status_type      mul_st;
   logic                 div_start;
   logic [DIV_W-1:0]     div_dividend;
   logic [DIV_W-1:0]     div_q;
   unit_status_type      div_st;

   // datapath next values
   logic        req_acc;
   logic        out_load;
   logic [15:0] cnt_sel;
   logic [15:0] diff_in;
   logic [31:0] speed_in;
   logic [31:0] err_in;
   logic [31:0] dterm_in;
   logic [48:0] esum_sum;
   logic [47:0] esum_in;
   logic [DIV_W-1:0] acc;
   logic [DIV_W-1:0] acc_mag;
   logic [DIV_W-1:0] q_neg;
   logic [31:0] avg_in;
   logic [DRV_W-1:0] drive_in;
   logic [DRV_W-1:0] drv_abs;
   logic        drv_over;
   logic [24:0] mag_in;
   logic [40:0] rnd;
   logic [15:0] duty;

   eps_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_prod),
      .status  (mul_st)
   );

   eps_div5 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .quotient (div_q),
      .status   (div_st)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         inv_period_ff <= 32'd6553600;
         invert_ff     <= 1'b0;
         pos_period_ff <= 16'hFFFF;
         neg_period_ff <= 16'hFFFF;
         neg_enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_GAIN_P:     gain_p_ff     <= csr_wdata;
            REG_GAIN_I:     gain_i_ff     <= csr_wdata;
            REG_GAIN_D:     gain_d_ff     <= csr_wdata;
            REG_INV_PERIOD: inv_period_ff <= csr_wdata;
            REG_INVERT:     invert_ff     <= csr_wdata[0];
            REG_POS_PERIOD: pos_period_ff <= csr_wdata[15:0];
            REG_NEG_PERIOD: neg_period_ff <= csr_wdata[15:0];
            REG_NEG_ENABLE: neg_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_acc) state_in = S_SPD_GO;
         S_SPD_GO:  state_in = S_SPD;
         S_SPD:     if (mul_st.done) state_in = S_ERR;
         S_ERR:     state_in = S_ERR2;
         S_ERR2:    state_in = S_PMUL;
         S_PMUL:    if (mul_st.done) state_in = S_I_GO;
         S_I_GO:    state_in = S_IMUL;
         S_IMUL:    if (mul_st.done) state_in = S_D_GO;
         S_D_GO:    state_in = S_DMUL;
         S_DMUL:    if (mul_st.done) state_in = S_CLAMP;
         S_CLAMP:   state_in = S_DUTY_GO;
         S_DUTY_GO: state_in = S_DUTY;
         S_DUTY:    if (mul_st.done) state_in = S_OUT;
         S_OUT:     if (out_load) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // multiplier operand routing
   always_comb begin
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         S_SPD_GO: begin
            mul_start = 1'b1;
            mul_a     = {17'b0, inv_period_ff};
            mul_b     = {{17{diff_ff[15]}}, diff_ff};
         end
         S_ERR2: begin
            mul_start = 1'b1;
            mul_a     = {{17{err_ff[31]}}, err_ff};
            mul_b     = {gain_p_ff[31], gain_p_ff};
         end
         S_I_GO: begin
            mul_start = 1'b1;
            mul_a     = {esum_ff[47], esum_ff};
            mul_b     = {gain_i_ff[31], gain_i_ff};
         end
         S_D_GO: begin
            mul_start = 1'b1;
            mul_a     = {{17{dterm_ff[31]}}, dterm_ff};
            mul_b     = {gain_d_ff[31], gain_d_ff};
         end
         S_DUTY_GO: begin
            mul_start = 1'b1;
            mul_a     = {24'b0, mag_ff};
            mul_b     = {17'b0, drv_neg_ff ? neg_period_ff : pos_period_ff};
         end
         default: ;
      endcase
   end

   always_comb begin
      cnt_sel = invert_ff ? (16'd0 - req_tdata[15:0]) : req_tdata[15:0];
      diff_in = cnt_sel - prev_count_ff;

      if ($signed(mul_prod) > P_S32_MAX) begin
         speed_in = 32'h7FFF_FFFF;
      end else if ($signed(mul_prod) < P_S32_MIN) begin
         speed_in = 32'h8000_0000;
      end else begin
         speed_in = mul_prod[31:0];
      end

      err_in   = sat33({target_ff[31], target_ff} - {speed_ff[31], speed_ff});
      dterm_in = sat33({prev_error_ff[31], prev_error_ff} - {err_ff[31], err_ff});

      esum_sum = {esum_ff[47], esum_ff} + {{17{err_ff[31]}}, err_ff};
      if (esum_sum[48] != esum_sum[47]) begin
         esum_in = esum_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      end else begin
         esum_in = esum_sum[47:0];
      end

      // 4*average + speed, divided by five on its magnitude with +2 rounding
      acc          = {speed_average_ff[31], speed_average_ff, 2'b00}
                   + {{3{speed_ff[31]}}, speed_ff};
      acc_mag      = acc[DIV_W-1] ? (DIV_W'(0) - acc) : acc;
      div_dividend = acc_mag + DIV_W'(2);
      q_neg        = DIV_W'(0) - div_q;
      avg_in       = acc_neg_ff ? q_neg[31:0] : div_q[31:0];

      // floor(product / 2^16) is the arithmetic shift
      drive_in = drive_ff + mul_prod[MUL_P_W-1:16];

      drv_abs  = drive_ff[DRV_W-1] ? (DRV_W'(0) - drive_ff) : drive_ff;
      drv_over = ($signed(drive_ff) > DRV_MAX) || ($signed(drive_ff) < DRV_MIN);
      mag_in   = drv_over ? MAG_ONE : drv_abs[24:0];

      rnd  = mul_prod[40:0] + ROUND_HALF;
      duty = rnd[39:24];
   end

   assign div_start = (state_ff == S_ERR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         prev_count_ff    <= '0;
         prev_error_ff    <= '0;
         esum_ff          <= '0;
         speed_average_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_acc) begin
            prev_count_ff <= cnt_sel;
         end
         if (state_ff == S_ERR2) begin
            prev_error_ff <= err_ff;
            esum_ff       <= esum_in;
         end
         if (div_st.done) begin
            speed_average_ff <= avg_in;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         diff_ff   <= diff_in;
         target_ff <= req_tdata[47:16];
      end
      if (state_ff == S_SPD && mul_st.done) begin
         speed_ff <= speed_in;
      end
      if (state_ff == S_ERR) begin
         err_ff     <= err_in;
         acc_neg_ff <= acc[DIV_W-1];
      end
      if (state_ff == S_ERR2) begin
         dterm_ff <= dterm_in;
      end
      if (state_ff == S_PMUL && mul_st.done) begin
         drive_ff <= mul_prod[MUL_P_W-1:16];
      end else if ((state_ff == S_IMUL || state_ff == S_DMUL) && mul_st.done) begin
         drive_ff <= drive_in;
      end
      if (state_ff == S_CLAMP) begin
         mag_ff     <= mag_in;
         drv_pos_ff <= !drive_ff[DRV_W-1] && (drive_ff != '0);
         drv_neg_ff <= drive_ff[DRV_W-1];
      end
      if (state_ff == S_DUTY && mul_st.done) begin
         pos_duty_ff <= drv_pos_ff ? duty : 16'd0;
         neg_duty_ff <= (drv_neg_ff && neg_enable_ff) ? duty : 16'd0;
      end
      if (out_load) begin
         rsp_data_ff <= {speed_average_ff, speed_ff, neg_duty_ff, pos_duty_ff};
      end
   end

   // checks
   a_mul_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_st.busy)
      else $error("multiplier started while busy");

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_st.busy)
      else $error("divider started while busy");

   a_mag_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUTY_GO) |-> (mag_ff <= MAG_ONE))
      else $error("drive magnitude above one");

   a_avg_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (!div_st.busy && !div_st.done))
      else $error("speed average not settled at output");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (state_ff == S_IDLE && !rsp_valid_ff))
      else $error("not idle after reset");

endmodule

`default_nettype wire

[hdl/eps_mul.sv]
`default_nettype none

// Radix-2 shift-add multiplier, one multiplier bit per cycle, LSB first.
// The sign bit of the multiplier is weighted negative, so the last step subtracts.
module eps_mul (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [eps_pkg::MUL_A_W-1:0]     a,
   input  wire logic [eps_pkg::MUL_B_W-1:0]     b,
   output logic      [eps_pkg::MUL_P_W-1:0]     product,
   output eps_pkg::unit_status_type             status
);
   import eps_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic [MUL_A_W-1:0]   a_ff;
   logic [MUL_A_W-1:0]   hi_ff;
   logic [MUL_B_W-1:0]   lo_ff;

   logic                 last;
   logic [MUL_A_W:0]     addend;
   logic [MUL_A_W:0]     sum;
   logic [MUL_A_W-1:0]   hi_in;
   logic [MUL_B_W-1:0]   lo_in;

   always_comb begin
      last = (cnt_ff == MUL_CNT_W'(MUL_B_W - 1));
      if (lo_ff[0]) begin
         addend = last ? ((MUL_A_W+1)'(0) - {a_ff[MUL_A_W-1], a_ff}) : {a_ff[MUL_A_W-1], a_ff};
      end else begin
         addend = '0;
      end
      sum   = {hi_ff[MUL_A_W-1], hi_ff} + addend;
      hi_in = sum[MUL_A_W:1];
      lo_in = {sum[0], lo_ff[MUL_B_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + MUL_CNT_W'(1);
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= a;
         hi_ff <= '0;
         lo_ff <= b;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign product     = {hi_ff, lo_ff};
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

[hdl/eps_div5.sv]
`default_nettype none

// Restoring division by five, one quotient bit per cycle, MSB first.
// Quotient bits shift into the dividend register as dividend bits leave.
module eps_div5 (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [eps_pkg::DIV_W-1:0]   dividend,
   output logic      [eps_pkg::DIV_W-1:0]   quotient,
   output eps_pkg::unit_status_type         status
);
   import eps_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     dq_ff;
   logic [2:0]           rem_ff;

   logic [3:0]           part;
   logic                 ge;
   logic [3:0]           part_sub;
   logic [2:0]           rem_in;
   logic [DIV_W-1:0]     dq_in;

   always_comb begin
      part     = {rem_ff, dq_ff[DIV_W-1]};
      ge       = (part >= DIV_BY);
      part_sub = part - DIV_BY;
      rem_in   = ge ? part_sub[2:0] : part[2:0];
      dq_in    = {dq_ff[DIV_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient    = dq_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
   import eps_pkg::*;

   // pos_duty in the low bits, as on rsp_tdata
   typedef struct packed {
      logic signed [31:0] smoothed_speed;
      logic signed [31:0] measured_speed;
      logic [15:0]        neg_duty;
      logic [15:0]        pos_duty;
   } duty_result_type;

   localparam longint S32_MIN = -64'sd2147483648;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S48_MIN = -64'sd140737488355328;
   localparam longint S48_MAX = 64'sd140737488355327;
   localparam longint Q24_ONE = 64'sd16777216;
   localparam int     IDLE_LIMIT = 5000;
   localparam int     TAIL_CYCLES = 250;

   class pwm_scoreboard_type;
      logic signed [31:0] gain_p, gain_i, gain_d;
      logic [31:0]        inv_period;
      bit                 encoder_invert, neg_enable;
      logic [15:0]        pos_period, neg_period;
      logic [15:0]        last_count;
      longint             last_error, error_sum, speed_avg;
      duty_result_type    expected_q[$];
      int unsigned        mismatches;

      function new();
         gain_p = 0;
         gain_i = 0;
         gain_d = 0;
         inv_period = 32'd6553600;
         encoder_invert = 0;
         pos_period = 16'hFFFF;
         neg_period = 16'hFFFF;
         neg_enable = 1;
         last_count = 0;
         last_error = 0;
         error_sum = 0;
         speed_avg = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_GAIN_P:     gain_p = v;
            REG_GAIN_I:     gain_i = v;
            REG_GAIN_D:     gain_d = v;
            REG_INV_PERIOD: inv_period = v;
            REG_INVERT:     encoder_invert = v[0];
            REG_POS_PERIOD: pos_period = v[15:0];
            REG_NEG_PERIOD: neg_period = v[15:0];
            REG_NEG_ENABLE: neg_enable = v[0];
            default: ;
         endcase
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // round half up, |drive| <= 1.0 keeps it within the period
      function logic [15:0] duty_of(longint mag, logic [15:0] period);
         longint t;
         t = (mag * longint'(period) + 64'sd8388608) >>> 24;
         return t[15:0];
      endfunction

      function void note_tick(logic [15:0] raw_count, logic signed [31:0] target);
         logic [15:0]     cnt, step;
         longint          speed, acc, err, dterm, drive, lo, hi;
         duty_result_type r;
         cnt = encoder_invert ? (16'h0 - raw_count) : raw_count;
         step = cnt - last_count;
         last_count = cnt;
         speed = clamp(longint'($signed(step)) * longint'(inv_period), S32_MIN, S32_MAX);
         acc = 4 * speed_avg + speed;
         speed_avg = (acc >= 0) ? (acc + 2) / 5 : -((-acc + 2) / 5);
         err = clamp(longint'(target) - speed, S32_MIN, S32_MAX);
         dterm = clamp(last_error - err, S32_MIN, S32_MAX);
         last_error = err;
         error_sum = clamp(error_sum + err, S48_MIN, S48_MAX);
         // integral product split so each partial stays in 64 bits
         lo = longint'(error_sum[15:0]);
         hi = error_sum >>> 16;
         drive = ((longint'(gain_p) * err) >>> 16)
               + ((longint'(gain_d) * dterm) >>> 16)
               + longint'(gain_i) * hi
               + ((longint'(gain_i) * lo) >>> 16);
         drive = clamp(drive, -Q24_ONE, Q24_ONE);
         r.pos_duty = 0;
         r.neg_duty = 0;
         if (drive > 0) begin
            r.pos_duty = duty_of(drive, pos_period);
         end else if (drive < 0 && neg_enable) begin
            r.neg_duty = duty_of(-drive, neg_period);
         end
         r.measured_speed = speed[31:0];
         r.smoothed_speed = speed_avg[31:0];
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [95:0] data);
         duty_result_type got, want;
         got = data;
         if (expected_q.size() == 0) begin
            $error("unexpected rsp transaction: %h", data);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (got.pos_duty !== want.pos_duty) begin
            $error("pos_duty: expected %0d, got %0d", want.pos_duty, got.pos_duty);
            mismatches++;
         end
         if (got.neg_duty !== want.neg_duty) begin
            $error("neg_duty: expected %0d, got %0d", want.neg_duty, got.neg_duty);
            mismatches++;
         end
         if (got.measured_speed !== want.measured_speed) begin
            $error("measured_speed: expected %0d, got %0d",
                   want.measured_speed, got.measured_speed);
            mismatches++;
         end
         if (got.smoothed_speed !== want.smoothed_speed) begin
            $error("smoothed_speed: expected %0d, got %0d",
                   want.smoothed_speed, got.smoothed_speed);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;     // encoder_count[15:0], target_speed[47:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;          // pos_duty[15:0], neg_duty[31:16],
                                    // measured_speed[63:32], smoothed_speed[95:64]
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = REG_GAIN_P;
   logic [31:0] csr_wdata = '0;

   pwm_scoreboard_type sb;
   int unsigned   burst_left = 0;
   int unsigned   gap_max = 0;
   int unsigned   idle_cycles = 0;
   int unsigned   ready_hold = 0;

   encoder_speed_pid_pwm uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // receiver: runs of ready, short stalls, occasional long stalls
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
      end
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               rsp_tready <= 1'b1;
               ready_hold <= $urandom_range(1, 300);
            end
            5, 6, 7: begin
               rsp_tready <= 1'b0;
               ready_hold <= $urandom_range(0, 8);
            end
            8: begin
               rsp_tready <= 1'b0;
               ready_hold <= $urandom_range(100, 400);
            end
            default: begin
               rsp_tready <= 1'($urandom_range(0, 1));
               ready_hold <= 0;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic logic [31:0] scaled_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         default: return $signed($urandom()) >>> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [15:0] pick_period();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_tick(input logic [15:0] count, input logic [31:0] target);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {target, count};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tick(count, target);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_controller_regs(input logic [31:0] kp, ki, kd, inv,
                                       input bit invert,
                                       input logic [15:0] pper, nper,
                                       input bit nen);
      logic [31:0] word [8];
      word[REG_GAIN_P] = kp;
      word[REG_GAIN_I] = ki;
      word[REG_GAIN_D] = kd;
      word[REG_INV_PERIOD] = inv;
      // unused upper bits carry noise
      word[REG_INVERT] = ($urandom() & 32'hFFFF_FFFE) | 32'(invert);
      word[REG_POS_PERIOD] = ($urandom() & 32'hFFFF_0000) | 32'(pper);
      word[REG_NEG_PERIOD] = ($urandom() & 32'hFFFF_0000) | 32'(nper);
      word[REG_NEG_ENABLE] = ($urandom() & 32'hFFFF_FFFE) | 32'(nen);
      for (int k = 0; k < 8; k++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 3'(k);
         csr_wdata <= word[k];
         @(posedge clock);
         sb.write_reg(3'(k), word[k]);
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [15:0] walk_count;
      logic [31:0] target;
      int          step_span;
      int          delta;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: zero gains, 100/s period
      send_tick(16'h0000, 32'h0000_0000);
      send_tick(16'h0005, 32'd6553600);
      send_tick(16'h0003, 32'h0000_0000);
      send_tick(16'hFFFF, 32'h7FFF_FFFF);
      wait_for_results();

      // saturating speed and error, inverted count, reverse output off
      load_controller_regs(32'h0100_0000, 32'h0000_0100, 32'h8000_0000, 32'hFFFF_FFFF,
                           1'b1, 16'hFFFF, 16'h1234, 1'b0);
      send_tick(16'h8000, 32'h8000_0000);
      send_tick(16'h7FFF, 32'h7FFF_FFFF);
      send_tick(16'h0000, 32'h0000_0000);
      send_tick(16'hFFFF, 32'hFFFF_FFFF);
      send_tick(16'h0001, 32'h0001_0000);
      send_tick(16'h0001, 32'h8000_0000);
      wait_for_results();

      // zero drive, zero periods
      load_controller_regs(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 16'h0000, 16'h0000, 1'b1);
      send_tick(16'h1234, 32'h7FFF_FFFF);
      send_tick(16'hFFFF, 32'h8000_0000);
      send_tick(16'h1000, 32'h0000_0000);
      wait_for_results();

      // small errors both ways into the proportional range
      load_controller_regs(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000,
                           1'b0, 16'd1000, 16'hFFFF, 1'b1);
      send_tick(16'h1000, 32'sd3);
      send_tick(16'h1000, -32'sd3);
      send_tick(16'h1000, 32'sd40);
      send_tick(16'h1000, -32'sd200);
      send_tick(16'h1001, 32'h0001_0000);
      send_tick(16'h1000, -32'sd1);
      wait_for_results();

      walk_count = 16'h1000;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: load_controller_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
            1: load_controller_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h0, 1'b0, 16'h0, 16'h0, 1'b0);
            default: load_controller_regs(scaled_word(), scaled_word(), scaled_word(),
                                          ($urandom_range(0, 3) == 0) ? scaled_word()
                                             : $urandom_range(0, 32'h0100_0000),
                                          1'($urandom_range(0, 1)), pick_period(),
                                          pick_period(), 1'($urandom_range(0, 1)));
         endcase
         case ($urandom_range(0, 3))
            0: step_span = 3;
            1: step_span = 60;
            2: step_span = 1000;
            default: step_span = 32767;
         endcase
         case (phase % 3)
            0: gap_max = 0;
            1: gap_max = 8;
            default: gap_max = 400;
         endcase
         burst_left = 0;
         for (int n = 0; n < 137; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               walk_count = 16'($urandom());
            end else begin
               delta = int'($urandom_range(0, 2 * step_span)) - step_span;
               walk_count = walk_count + 16'(delta);
            end
            case ($urandom_range(0, 9))
               0, 1: target = $urandom();
               2:    target = 32'h0000_0000;
               default: target = $signed($urandom()) >>> $urandom_range(6, 31);
            endcase
            send_tick(walk_count, target);
         end
         wait_for_results();
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/eps_pkg.sv
hdl/eps_mul.sv
hdl/eps_div5.sv
hdl/encoder_speed_pid_pwm.sv
tb/tb.sv
